### src/crtc_pkg.sv
// Shared types, codes and constants for the CRTC timing and register file.
// Used by crtc_timing_and_register_file; depends on nothing.
package crtc_pkg;

    localparam int REG_COUNT_DEF   = 32;
    localparam int FRAME_LINES_DEF = 360;

    // Item codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Port offsets above the aliased index/data window
    localparam logic [3:0] PORT_MODE   = 4'h8;
    localparam logic [3:0] PORT_COLOUR = 4'h9;
    localparam logic [3:0] PORT_STATUS = 4'hA;
    localparam logic [3:0] PORT_EXT    = 4'hD;

    // Register indexes with special handling
    localparam logic [4:0] IDX_R10 = 5'h10;
    localparam logic [4:0] IDX_R12 = 5'h12;

    localparam logic [7:0] R10_READ_KEEP    = 8'h13;
    localparam logic [7:0] R10_MODE_BITS    = 8'h88;
    localparam logic [7:0] CURSOR_MODE_MASK = 8'h60;
    localparam logic [7:0] CURSOR_OFF       = 8'h20;
    localparam logic [7:0] CURSOR_SLOW      = 8'h60;
    localparam logic [7:0] EXT_MODE_RESET   = 8'h80;
    localparam logic [4:0] VSYNC_LEN        = 5'd16;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] port;
        logic [7:0] write_data;
    } crtc_in_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        display_enable;
        logic [7:0]  status_byte;
        logic        cursor_here;
        logic [15:0] memory_address;
        logic [4:0]  row_address;
        logic [8:0]  line_number;
    } crtc_out_t;

    // Write mask per register; registers 18 and up hold nothing
    function automatic logic [7:0] reg_mask(input logic [4:0] idx);
        logic [7:0] m;
        begin
            case (idx) inside
                [5'd0:5'd3]:   m = 8'hFF;
                5'd4:          m = 8'h7F;
                5'd5:          m = 8'h1F;
                5'd6:          m = 8'h7F;
                5'd7:          m = 8'h7F;
                5'd8:          m = 8'hF3;
                5'd9:          m = 8'h1F;
                5'd10:         m = 8'h7F;
                5'd11:         m = 8'h1F;
                5'd12:         m = 8'h3F;
                5'd13:         m = 8'hFF;
                5'd14:         m = 8'h3F;
                [5'd15:5'd17]: m = 8'hFF;
                default:       m = 8'h00;
            endcase
            return m;
        end
    endfunction

endpackage

### src/crtc_timing_and_register_file.sv
// 6845-style display timing controller with its port register file.
// Depends on crtc_pkg for the channel structs, codes and write masks.
//
// Usage: one request channel (req_valid/req_stall/req) carries items: a
// half-scanline tick, a port write or a port read. One response channel
// (rsp_valid/rsp_stall/rsp) returns exactly one result per item: the read
// byte (0 for ticks and writes) and the counters and status as they stand
// after that item.
// The result of an item transferred at one edge stands in the response register
// from the next cycle. Throughput is one item per cycle while the receiver does
// not stall; all register and counter updates for an item are done by the
// compare/add logic in front of the state registers in the cycle of the
// transfer.
// While the receiver stalls with a result held, req_stall is raised and no
// item is taken; the held result does not change. A new item is taken in
// the same cycle the held result is transferred.
// Reset clears the register file, counters and status (extended mode
// register to 0x80) and empties the response register.
module crtc_timing_and_register_file #(
    parameter int REG_COUNT   = crtc_pkg::REG_COUNT_DEF,
    parameter int FRAME_LINES = crtc_pkg::FRAME_LINES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  crtc_pkg::crtc_in_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output crtc_pkg::crtc_out_t rsp
);
    import crtc_pkg::*;

    localparam int         IDX_W     = $clog2(REG_COUNT);
    localparam logic [5:0] REG_CNT_W = 6'(REG_COUNT);
    localparam logic [9:0] FRAME_W   = 10'(FRAME_LINES);

    logic [7:0]  crtc_regs_reg [REG_COUNT];
    logic [7:0]  crtc_regs_next [REG_COUNT];
    logic [4:0]  reg_index_reg, reg_index_next;
    logic [7:0]  mode_reg, mode_next;
    logic [7:0]  colour_reg, colour_next;
    logic [7:0]  ext_mode_reg, ext_mode_next;
    logic [7:0]  status_reg, status_next;
    logic        phase_reg, phase_next;
    logic [4:0]  row_reg, row_next;
    logic [6:0]  vert_reg, vert_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] row_start_reg, row_start_next;
    logic [4:0]  vadj_reg, vadj_next;
    logic [4:0]  vsync_reg, vsync_next;
    logic        cur_win_reg, cur_win_next;
    logic        blink_on_reg, blink_on_next;
    logic [7:0]  blink_cnt_reg, blink_cnt_next;
    logic        disp_on_reg, disp_on_next;
    logic        odd_even_reg, odd_even_next;
    logic [8:0]  line_reg, line_next;

    logic        rsp_valid_reg;
    crtc_out_t   rsp_reg, rsp_next;
    logic        accept;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic [7:0]  rd;
        logic [7:0]  sel;
        logic        interlace;
        logic [4:0]  cur_end;
        logic [4:0]  cur_start;
        logic [6:0]  prev_vert;
        logic [9:0]  line_inc;
        logic [15:0] start_addr;
        logic [15:0] cursor_addr;

        for (int i = 0; i < REG_COUNT; i++)
        begin
            crtc_regs_next[i] = crtc_regs_reg[i];
        end
        reg_index_next = reg_index_reg;
        mode_next      = mode_reg;
        colour_next    = colour_reg;
        ext_mode_next  = ext_mode_reg;
        status_next    = status_reg;
        phase_next     = phase_reg;
        row_next       = row_reg;
        vert_next      = vert_reg;
        addr_next      = addr_reg;
        row_start_next = row_start_reg;
        vadj_next      = vadj_reg;
        vsync_next     = vsync_reg;
        cur_win_next   = cur_win_reg;
        blink_on_next  = blink_on_reg;
        blink_cnt_next = blink_cnt_reg;
        disp_on_next   = disp_on_reg;
        odd_even_next  = odd_even_reg;
        line_next      = line_reg;
        rd             = 8'h00;

        sel = (reg_index_reg < REG_CNT_W) ? crtc_regs_reg[reg_index_reg[IDX_W-1:0]] : 8'h00;
        interlace  = (crtc_regs_reg[8][1:0] == 2'b11);
        cur_end    = crtc_regs_reg[11][4:0];
        cur_start  = crtc_regs_reg[10][4:0];
        start_addr = {crtc_regs_reg[12], crtc_regs_reg[13]};
        prev_vert  = vert_reg;
        line_inc   = {1'b0, line_reg} + 10'd1;

        unique case (req.opcode)
            OP_TICK:
            begin
                if (!phase_reg)
                begin
                    // line start half
                    status_next = status_next | 8'h01;
                    phase_next  = 1'b1;
                    if (disp_on_reg)
                        addr_next = addr_reg + {8'h00, crtc_regs_reg[1]};
                    if ({1'b0, vert_reg} == crtc_regs_reg[7] && row_reg == 5'd0)
                        status_next = status_next | 8'h08;
                    line_next = (line_inc >= FRAME_W) ? 9'd0 : line_inc[8:0];
                end
                else
                begin
                    // line end half
                    phase_next = 1'b0;
                    if (vsync_reg != 5'd0)
                    begin
                        vsync_next = vsync_reg - 5'd1;
                        if (vsync_next == 5'd0)
                            status_next = status_next & ~8'h08;
                    end
                    if (row_reg == cur_end || (interlace && row_reg == (cur_end >> 1)))
                        cur_win_next = 1'b0;
                    if (interlace && {3'b000, row_reg} == {1'b0, crtc_regs_reg[9][7:1]})
                        row_start_next = addr_reg;

                    if (vadj_reg != 5'd0)
                    begin
                        row_next  = row_reg + 5'd1;
                        addr_next = row_start_next;
                        vadj_next = vadj_reg - 5'd1;
                        if (vadj_next == 5'd0)
                        begin
                            disp_on_next   = 1'b1;
                            addr_next      = start_addr;
                            row_start_next = start_addr;
                            row_next       = 5'd0;
                        end
                    end
                    else if ({3'b000, row_reg} == crtc_regs_reg[9])
                    begin
                        row_start_next = addr_reg;
                        row_next       = 5'd0;
                        vert_next      = vert_reg + 7'd1;
                        if ({1'b0, vert_next} == crtc_regs_reg[6])
                            disp_on_next = 1'b0;
                        if ({1'b0, prev_vert} == crtc_regs_reg[4])
                        begin
                            vert_next = 7'd0;
                            vadj_next = crtc_regs_reg[5][4:0];
                            if (vadj_next == 5'd0)
                            begin
                                disp_on_next   = 1'b1;
                                addr_next      = start_addr;
                                row_start_next = start_addr;
                            end
                            case (crtc_regs_reg[10] & CURSOR_MODE_MASK)
                                CURSOR_OFF:  blink_on_next = 1'b0;
                                CURSOR_SLOW: blink_on_next = blink_cnt_reg[4];
                                default:     blink_on_next = blink_cnt_reg[3];
                            endcase
                        end
                        if ({1'b0, vert_next} == crtc_regs_reg[7])
                        begin
                            disp_on_next   = 1'b0;
                            line_next      = 9'd0;
                            vsync_next     = VSYNC_LEN;
                            blink_cnt_next = blink_cnt_reg + 8'd1;
                            odd_even_next  = !odd_even_reg;
                        end
                    end
                    else
                    begin
                        row_next  = row_reg + 5'd1;
                        addr_next = row_start_next;
                    end

                    if (disp_on_next)
                        status_next = status_next & ~8'h01;
                    if (row_next == cur_start || (interlace && row_next == (cur_start >> 1)))
                        cur_win_next = 1'b1;
                end
            end
            OP_WRITE:
            begin
                if (!req.port[3])
                begin
                    if (!req.port[0])
                        reg_index_next = req.write_data[4:0];
                    else if (!(crtc_regs_reg[16][7] && reg_index_reg <= 5'd7)
                             && reg_index_reg < REG_CNT_W)
                        crtc_regs_next[reg_index_reg[IDX_W-1:0]] =
                            req.write_data & reg_mask(reg_index_reg);
                end
                else
                begin
                    case (req.port)
                        PORT_MODE:   mode_next     = req.write_data;
                        PORT_COLOUR: colour_next   = req.write_data;
                        PORT_EXT:    ext_mode_next = req.write_data;
                        default:     ;
                    endcase
                end
            end
            OP_READ:
            begin
                if (!req.port[3])
                begin
                    if (!req.port[0])
                        rd = {3'b000, reg_index_reg};
                    else
                    begin
                        rd = (reg_index_reg == IDX_R12 && crtc_regs_reg[17][7]) ? 8'h02 : sel;
                        if (reg_index_reg == IDX_R10)
                        begin
                            rd = rd & R10_READ_KEEP;
                            if (mode_reg[0])
                                rd = rd | R10_MODE_BITS;
                        end
                    end
                end
                else
                begin
                    case (req.port)
                        PORT_STATUS: rd = status_reg;
                        PORT_EXT:    rd = ext_mode_reg;
                        default:     rd = 8'hFF;
                    endcase
                end
            end
            default: ;
        endcase

        cursor_addr = {crtc_regs_next[14], crtc_regs_next[15]};

        rsp_next.read_data      = rd;
        rsp_next.display_enable = disp_on_next;
        rsp_next.status_byte    = status_next;
        rsp_next.cursor_here    = (addr_next == cursor_addr) && cur_win_next && blink_on_next;
        rsp_next.memory_address = addr_next;
        rsp_next.row_address    = row_next;
        rsp_next.line_number    = line_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                crtc_regs_reg[i] <= 8'h00;
            end
            reg_index_reg <= 5'd0;
            mode_reg      <= 8'h00;
            colour_reg    <= 8'h00;
            ext_mode_reg  <= EXT_MODE_RESET;
            status_reg    <= 8'h00;
            phase_reg     <= 1'b0;
            row_reg       <= 5'd0;
            vert_reg      <= 7'd0;
            addr_reg      <= 16'h0000;
            row_start_reg <= 16'h0000;
            vadj_reg      <= 5'd0;
            vsync_reg     <= 5'd0;
            cur_win_reg   <= 1'b0;
            blink_on_reg  <= 1'b0;
            blink_cnt_reg <= 8'h00;
            disp_on_reg   <= 1'b0;
            odd_even_reg  <= 1'b0;
            line_reg      <= 9'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int i = 0; i < REG_COUNT; i++)
                begin
                    crtc_regs_reg[i] <= crtc_regs_next[i];
                end
                reg_index_reg <= reg_index_next;
                mode_reg      <= mode_next;
                colour_reg    <= colour_next;
                ext_mode_reg  <= ext_mode_next;
                status_reg    <= status_next;
                phase_reg     <= phase_next;
                row_reg       <= row_next;
                vert_reg      <= vert_next;
                addr_reg      <= addr_next;
                row_start_reg <= row_start_next;
                vadj_reg      <= vadj_next;
                vsync_reg     <= vsync_next;
                cur_win_reg   <= cur_win_next;
                blink_on_reg  <= blink_on_next;
                blink_cnt_reg <= blink_cnt_next;
                disp_on_reg   <= disp_on_next;
                odd_even_reg  <= odd_even_next;
                line_reg      <= line_next;
            end
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // result payload carries no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("transferred item produced no result");

    a_line_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg < FRAME_LINES[8:0] || FRAME_LINES == 511)
        else $error("display line counter beyond frame length");

    a_vsync_len: assert property (@(posedge clk) disable iff (!rst_n)
        vsync_reg <= VSYNC_LEN)
        else $error("vsync counter beyond sync length");

    a_timing_protect: assert property (@(posedge clk) disable iff (!rst_n)
        crtc_regs_reg[16][7] |=> $stable(crtc_regs_reg[0]) && $stable(crtc_regs_reg[7]))
        else $error("protected timing register changed");

endmodule
